[hdl/qapm_pkg.sv]
`default_nettype none

package qapm_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [2:0] REG_YAW_PROP_GAIN  = 3'd3;
  localparam logic [2:0] REG_YAW_DERIV_GAIN = 3'd4;
  localparam logic [2:0] REG_INTEG_WINDOW   = 3'd5;
  localparam logic [2:0] REG_INTEG_CLAMP    = 3'd6;
  localparam logic [2:0] REG_AXIS_CLAMP     = 3'd7;

  // Function codes of an input beat
  localparam logic FUNC_STEP  = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [10:0] MOTOR_MIN = 11'd1000;
  localparam logic [10:0] MOTOR_MAX = 11'd2000;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [15:0] yaw_prop_gain;
    logic [15:0] yaw_deriv_gain;
    logic [14:0] integ_window;
    logic [9:0]  integ_clamp;
    logic [9:0]  axis_clamp;
  } cfg_t;

  // Stage advance strobes shared by all lanes
  typedef struct packed {
    logic acc;      // input beat taken into stage 1
    logic clr_in;   // the beat being taken is a clear
    logic en2;
    logic en3;
    logic en4;
    logic int_upd;  // a valid item moves from stage 2 to stage 3
    logic int_clr;  // that item is a clear
  } pipe_ctl_t;

  // Symmetric clamp to +-lim, result fits 11 bits signed
  function automatic logic signed [10:0] clamp_sym(input logic signed [23:0] v,
                                                   input logic [9:0] lim);
    logic signed [23:0] hi;
    logic signed [23:0] lo;
    logic signed [23:0] r;
    hi = $signed({14'd0, lim});
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[10:0];
  endfunction

endpackage

`default_nettype wire

[hdl/quad_attitude_pid_mixer_top.sv]
`default_nettype none

// Quadcopter attitude controller with X-frame mixer. Each input beat carries
// throttle, pitch/roll angle targets, a yaw-rate target and the current and
// previous IMU angles (Q8.8 degrees); a control beat yields one result beat of
// four motor pulses (1000..2000 us), a clear beat (func_i = 1) zeros the
// integrators and history and yields nothing. The block takes one beat per
// clock while in_stall_o is low, and each beat passes through a pipeline:
// four lane stages (error, gain products, integrator/sum, floor/clamp) run in
// three side-by-side lanes (pitch PID, roll PID, yaw PD) and the mixer stage
// merges them into the output register. The integrator recurrence closes in
// stage 3 with one add and clamp per cycle, and target/yaw history closes at
// the input, so back-to-back beats see the state of the beat just before.
// Stages only hold when the stage after is full and held, so bubbles
// collapse and in_stall_o rises only with a full pipeline and a held output.
// Gains and limits sit on an APB port at byte address 4*index (prdata reads
// them back); write them only while no beat is in flight.

module quad_attitude_pid_mixer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [10:0]        throttle_i,
  input  logic signed [15:0] pitch_target_i,
  input  logic signed [15:0] roll_target_i,
  input  logic signed [15:0] yaw_rate_target_i,
  input  logic signed [15:0] pitch_now_i,
  input  logic signed [15:0] roll_now_i,
  input  logic signed [15:0] yaw_now_i,
  input  logic signed [15:0] pitch_before_i,
  input  logic signed [15:0] roll_before_i,
  input  logic signed [15:0] yaw_before_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [10:0]        motor_a_o,
  output logic [10:0]        motor_b_o,
  output logic [10:0]        motor_c_o,
  output logic [10:0]        motor_d_o
);

  qapm_pkg::cfg_t      cfg_q;
  qapm_pkg::pipe_ctl_t ctl;

  logic [2:0] reg_idx;
  logic       wr_en;

  // Stage valids, clear flags and the throttle that rides alongside the lanes
  logic        v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic        clr1_q, clr2_q;
  logic [10:0] thr1_q, thr2_q, thr3_q, thr4_q;
  logic        en1, en2, en3, en4, en5;
  logic        acc;

  logic signed [10:0] pitch_axis, roll_axis, yaw_axis;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        qapm_pkg::REG_PROP_GAIN:      cfg_q.prop_gain      <= pwdata[15:0];
        qapm_pkg::REG_INTEG_GAIN:     cfg_q.integ_gain     <= pwdata[15:0];
        qapm_pkg::REG_DERIV_GAIN:     cfg_q.deriv_gain     <= pwdata[15:0];
        qapm_pkg::REG_YAW_PROP_GAIN:  cfg_q.yaw_prop_gain  <= pwdata[15:0];
        qapm_pkg::REG_YAW_DERIV_GAIN: cfg_q.yaw_deriv_gain <= pwdata[15:0];
        qapm_pkg::REG_INTEG_WINDOW:   cfg_q.integ_window   <= pwdata[14:0];
        qapm_pkg::REG_INTEG_CLAMP:    cfg_q.integ_clamp    <= pwdata[9:0];
        qapm_pkg::REG_AXIS_CLAMP:     cfg_q.axis_clamp     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      qapm_pkg::REG_PROP_GAIN:      prdata = {16'd0, cfg_q.prop_gain};
      qapm_pkg::REG_INTEG_GAIN:     prdata = {16'd0, cfg_q.integ_gain};
      qapm_pkg::REG_DERIV_GAIN:     prdata = {16'd0, cfg_q.deriv_gain};
      qapm_pkg::REG_YAW_PROP_GAIN:  prdata = {16'd0, cfg_q.yaw_prop_gain};
      qapm_pkg::REG_YAW_DERIV_GAIN: prdata = {16'd0, cfg_q.yaw_deriv_gain};
      qapm_pkg::REG_INTEG_WINDOW:   prdata = {17'd0, cfg_q.integ_window};
      qapm_pkg::REG_INTEG_CLAMP:    prdata = {22'd0, cfg_q.integ_clamp};
      qapm_pkg::REG_AXIS_CLAMP:     prdata = {22'd0, cfg_q.axis_clamp};
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline control: a stage advances when it is empty or the next advances
  // ---------------------------------------------------------------------
  assign en5 = !out_valid_q || !out_stall_i;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign acc = in_valid_i && en1;

  assign in_stall_o  = !en1;
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctl.acc     = acc;
    ctl.clr_in  = (func_i == qapm_pkg::FUNC_CLEAR);
    ctl.en2     = en2;
    ctl.en3     = en3;
    ctl.en4     = en4;
    ctl.int_upd = en3 && v2_q;
    ctl.int_clr = clr2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      // drop clear beats once the integrators have seen them
      if (en3) begin
        v3_q <= v2_q && !clr2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        out_valid_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      clr1_q <= (func_i == qapm_pkg::FUNC_CLEAR);
      thr1_q <= throttle_i;
    end
    if (en2) begin
      clr2_q <= clr1_q;
      thr2_q <= thr1_q;
    end
    if (en3) begin
      thr3_q <= thr2_q;
    end
    if (en4) begin
      thr4_q <= thr3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Lanes and mixer
  // ---------------------------------------------------------------------
  qapm_pid_lane u_pitch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg_q),
    .now_i    (pitch_now_i),
    .target_i (pitch_target_i),
    .before_i (pitch_before_i),
    .axis_o   (pitch_axis)
  );

  qapm_pid_lane u_roll (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg_q),
    .now_i    (roll_now_i),
    .target_i (roll_target_i),
    .before_i (roll_before_i),
    .axis_o   (roll_axis)
  );

  qapm_yaw_lane u_yaw (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg_q),
    .now_i    (yaw_now_i),
    .before_i (yaw_before_i),
    .rate_i   (yaw_rate_target_i),
    .axis_o   (yaw_axis)
  );

  qapm_mixer u_mixer (
    .clk_i        (clk_i),
    .en_i         (en5),
    .axis_clamp_i (cfg_q.axis_clamp),
    .throttle_i   (thr4_q),
    .pitch_i      (pitch_axis),
    .roll_i       (roll_axis),
    .yaw_i        (yaw_axis),
    .motor_a_o    (motor_a_o),
    .motor_b_o    (motor_b_o),
    .motor_c_o    (motor_c_o),
    .motor_d_o    (motor_d_o)
  );

endmodule

`default_nettype wire

[hdl/qapm_pid_lane.sv]
`default_nettype none

module qapm_pid_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qapm_pkg::pipe_ctl_t       ctl_i,
  input  qapm_pkg::cfg_t            cfg_i,
  input  logic signed [15:0]        now_i,
  input  logic signed [15:0]        target_i,
  input  logic signed [15:0]        before_i,
  output logic signed [10:0]        axis_o
);

  logic signed [15:0] last_tgt_q;
  logic signed [19:0] integ_q;

  logic signed [16:0] err1_d, err1_q;
  logic signed [17:0] dd1_d, dd1_q;
  logic [16:0]        mag;
  logic               win1_d, win1_q;

  logic signed [33:0] p2_d, p2_q;
  logic signed [34:0] d2_d, d2_q;
  logic signed [33:0] iprod;
  logic signed [33:0] ishift;
  logic signed [25:0] inc2_d, inc2_q;

  logic signed [35:0] sum3_d, sum3_q;
  logic signed [26:0] accsum;
  logic signed [26:0] ilim;
  logic signed [19:0] acc3_d, acc3_q;

  logic signed [36:0] tot4;
  logic signed [36:0] tot4_sh;
  logic signed [10:0] axis4_q;

  // Stage 1: error, derivative difference, window test
  always_comb begin
    err1_d = {now_i[15], now_i} - {target_i[15], target_i};
    dd1_d  = {err1_d[16], err1_d} - {{2{before_i[15]}}, before_i}
           + {{2{last_tgt_q[15]}}, last_tgt_q};
    mag    = err1_d[16] ? 17'(-err1_d) : 17'(err1_d);
    win1_d = mag < {2'b00, cfg_i.integ_window};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tgt_q <= '0;
    end else if (ctl_i.acc) begin
      last_tgt_q <= ctl_i.clr_in ? 16'sd0 : target_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      err1_q <= err1_d;
      dd1_q  <= dd1_d;
      win1_q <= win1_d;
    end
  end

  // Stage 2: gain products
  always_comb begin
    p2_d   = $signed({1'b0, cfg_i.prop_gain}) * err1_q;
    d2_d   = $signed({1'b0, cfg_i.deriv_gain}) * dd1_q;
    iprod  = $signed({1'b0, cfg_i.integ_gain}) * err1_q;
    ishift = iprod >>> 8;
    inc2_d = win1_q ? ishift[25:0] : 26'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      p2_q   <= p2_d;
      d2_q   <= d2_d;
      inc2_q <= inc2_d;
    end
  end

  // Stage 3: integrator update and clamp, P + D
  always_comb begin
    sum3_d = {{2{p2_q[33]}}, p2_q} + {d2_q[34], d2_q};
    accsum = {{7{integ_q[19]}}, integ_q} + {inc2_q[25], inc2_q};
    ilim   = $signed({9'd0, cfg_i.integ_clamp, 8'd0});
    if (accsum > ilim) begin
      acc3_d = ilim[19:0];
    end else if (accsum < -ilim) begin
      acc3_d = 20'(-ilim);
    end else begin
      acc3_d = accsum[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctl_i.int_upd) begin
      integ_q <= ctl_i.int_clr ? 20'sd0 : acc3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      sum3_q <= sum3_d;
      acc3_q <= acc3_d;
    end
  end

  // Stage 4: floor to whole us and clamp
  always_comb begin
    tot4    = {sum3_q[35], sum3_q} + {{9{acc3_q[19]}}, acc3_q, 8'd0};
    tot4_sh = tot4 >>> 16;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en4) begin
      axis4_q <= qapm_pkg::clamp_sym(tot4_sh[23:0], cfg_i.axis_clamp);
    end
  end

  assign axis_o = axis4_q;

endmodule

`default_nettype wire

[hdl/qapm_yaw_lane.sv]
`default_nettype none

module qapm_yaw_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qapm_pkg::pipe_ctl_t       ctl_i,
  input  qapm_pkg::cfg_t            cfg_i,
  input  logic signed [15:0]        now_i,
  input  logic signed [15:0]        before_i,
  input  logic signed [15:0]        rate_i,
  output logic signed [10:0]        axis_o
);

  logic signed [17:0] last_err_q;

  logic signed [17:0] err1_d, err1_q;
  logic signed [18:0] dd1_d, dd1_q;
  logic signed [34:0] p2_d, p2_q;
  logic signed [35:0] d2_d, d2_q;
  logic signed [36:0] sum3_q;
  logic signed [36:0] sum3_sh;
  logic signed [10:0] axis4_q;

  // Stage 1: yaw error is angle change plus the rate target
  always_comb begin
    err1_d = {{2{now_i[15]}}, now_i} - {{2{before_i[15]}}, before_i}
           + {{2{rate_i[15]}}, rate_i};
    dd1_d  = {err1_d[17], err1_d} - {last_err_q[17], last_err_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else if (ctl_i.acc) begin
      last_err_q <= ctl_i.clr_in ? 18'sd0 : err1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      err1_q <= err1_d;
      dd1_q  <= dd1_d;
    end
  end

  // Stage 2: gain products
  always_comb begin
    p2_d = $signed({1'b0, cfg_i.yaw_prop_gain}) * err1_q;
    d2_d = $signed({1'b0, cfg_i.yaw_deriv_gain}) * dd1_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      p2_q <= p2_d;
      d2_q <= d2_d;
    end
  end

  // Stage 3: P + D; stage 4: floor and clamp
  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      sum3_q <= {{2{p2_q[34]}}, p2_q} + {d2_q[35], d2_q};
    end
  end

  assign sum3_sh = sum3_q >>> 16;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en4) begin
      axis4_q <= qapm_pkg::clamp_sym(sum3_sh[23:0], cfg_i.axis_clamp);
    end
  end

  assign axis_o = axis4_q;

endmodule

`default_nettype wire

[hdl/qapm_mixer.sv]
`default_nettype none

module qapm_mixer (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [9:0]         axis_clamp_i,
  input  logic [10:0]        throttle_i,
  input  logic signed [10:0] pitch_i,
  input  logic signed [10:0] roll_i,
  input  logic signed [10:0] yaw_i,
  output logic [10:0]        motor_a_o,
  output logic [10:0]        motor_b_o,
  output logic [10:0]        motor_c_o,
  output logic [10:0]        motor_d_o
);

  function automatic logic [10:0] pulse(input logic signed [12:0] mix,
                                        input logic [10:0] thr,
                                        input logic [9:0] lim);
    logic signed [10:0] c;
    logic signed [13:0] s;
    logic [10:0]        r;
    c = qapm_pkg::clamp_sym({{11{mix[12]}}, mix}, lim);
    s = $signed({3'b000, thr}) + {{3{c[10]}}, c};
    if (s < $signed({3'b000, qapm_pkg::MOTOR_MIN})) begin
      r = qapm_pkg::MOTOR_MIN;
    end else if (s > $signed({3'b000, qapm_pkg::MOTOR_MAX})) begin
      r = qapm_pkg::MOTOR_MAX;
    end else begin
      r = s[10:0];
    end
    return r;
  endfunction

  logic signed [12:0] p13, r13, y13;
  logic signed [12:0] mix_a, mix_b, mix_c, mix_d;

  always_comb begin
    p13   = {{2{pitch_i[10]}}, pitch_i};
    r13   = {{2{roll_i[10]}}, roll_i};
    y13   = {{2{yaw_i[10]}}, yaw_i};
    mix_a = -p13 + r13 - y13;
    mix_b = -p13 - r13 + y13;
    mix_c =  p13 - r13 - y13;
    mix_d =  p13 + r13 + y13;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      motor_a_o <= pulse(mix_a, throttle_i, axis_clamp_i);
      motor_b_o <= pulse(mix_b, throttle_i, axis_clamp_i);
      motor_c_o <= pulse(mix_c, throttle_i, axis_clamp_i);
      motor_d_o <= pulse(mix_d, throttle_i, axis_clamp_i);
    end
  end

endmodule

`default_nettype wire

[hdl/qapm_checker.sv]
`default_nettype none

module qapm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [10:0] motor_a_o,
  input logic [10:0] motor_b_o,
  input logic [10:0] motor_c_o,
  input logic [10:0] motor_d_o
);

  // A held result beat stays and keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(motor_a_o)
      && $stable(motor_b_o) && $stable(motor_c_o) && $stable(motor_d_o))
    else $error("result beat changed while stalled");

  // Input backs up only behind a full pipeline with a held output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A full pipeline released at the output takes the next beat
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  // Every pulse lies inside the motor range
  a_motor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> motor_a_o >= 11'd1000 && motor_a_o <= 11'd2000
      && motor_b_o >= 11'd1000 && motor_b_o <= 11'd2000
      && motor_c_o >= 11'd1000 && motor_c_o <= 11'd2000
      && motor_d_o >= 11'd1000 && motor_d_o <= 11'd2000)
    else $error("motor pulse out of range");

endmodule

bind quad_attitude_pid_mixer_top qapm_checker u_qapm_checker (.*);

`default_nettype wire
